// ===== rtl/core/ccv_pkg.sv =====
// ----------------------------------------------------------------------------
// ccv_pkg
// Types and constants for the column consensus vote block.
// ----------------------------------------------------------------------------
package ccv_pkg;

	localparam int unsigned SYM_BASE     = 45;
	localparam int unsigned NUM_BINS     = 46;
	localparam int unsigned BIN_W        = $clog2(NUM_BINS);
	localparam int unsigned SYM_W        = 7;
	localparam int unsigned CNT_OUT_W    = 11;
	localparam int unsigned MAX_SEQS_DEF = 1024;

	localparam logic [7:0]       SYM_LO = 8'(SYM_BASE);
	localparam logic [7:0]       SYM_HI = 8'(SYM_BASE + NUM_BINS - 1);
	localparam logic [SYM_W-1:0] DASH   = SYM_W'(SYM_BASE);

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} sym_item_t;

	typedef struct packed {
		logic [SYM_W-1:0]     consensus_symbol;
		logic [CNT_OUT_W-1:0] winning_count;
	} vote_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_INC   = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} ccv_state_t;

endpackage

// ===== rtl/core/column_consensus_vote.sv =====
// ----------------------------------------------------------------------------
// column_consensus_vote
// Plurality consensus of one alignment column, one character per transaction.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  sym     | in  | sym_valid / sym_stall   | sym_data  (symbol, last)
//  vote    | out | vote_valid / vote_stall | vote_data (consensus_symbol,
//          |     |                         |            winning_count)
//  cfg     | in  | cfg_we                  | cfg_wdata (unanimous_mode)
//
//  A character without last goes through accept, then read-modify-write
//  of its bin in the single-port bin memory.
//  A last character then goes on to scan, drain and done: the 46 bins are read one per
//  cycle through the same port into one shared compare unit.
//  The result waits in the output register; the next column is taken
//  meanwhile, and its end waits only while that register is still full.
//  Reset clears the bin valid bits, the column height and the mode register.
// ----------------------------------------------------------------------------
module column_consensus_vote #(
	parameter int unsigned MAX_SEQS = ccv_pkg::MAX_SEQS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_stall,
	input  ccv_pkg::sym_item_t sym_data,
	output logic              vote_valid,
	input  logic              vote_stall,
	output ccv_pkg::vote_t    vote_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import ccv_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SEQS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEQS);

	ccv_state_t            state_q;
	logic                  mode_q;
	logic [CNT_W-1:0]      height_q;
	logic [NUM_BINS-1:0]   vld_q;
	logic [CNT_W-1:0]      mem [NUM_BINS];
	logic [CNT_W-1:0]      rd_q;
	logic                  rdv_q;
	logic [BIN_W-1:0]      bin_q;
	logic                  last_q;
	logic [BIN_W-1:0]      scan_q;
	logic [BIN_W-1:0]      rd_bin_s1;
	logic                  cmp_vld_s1;
	logic [CNT_W-1:0]      best_q;
	logic [BIN_W-1:0]      best_bin_q;
	logic                  vote_valid_q;
	vote_t                 vote_q;

	logic                  accept;
	logic [BIN_W-1:0]      bin_in;
	logic [BIN_W-1:0]      rd_addr;
	logic                  rd_en;
	logic                  wr_en;
	logic [CNT_W-1:0]      rd_val;
	logic [CNT_W-1:0]      inc_val;
	logic                  out_free;
	logic [SYM_W-1:0]      win_sym;

	assign sym_stall  = (state_q != ST_IDLE);
	assign accept     = sym_valid && !sym_stall;
	assign vote_valid = vote_valid_q;
	assign vote_data  = vote_q;
	assign out_free   = !vote_valid_q || !vote_stall;

	always_comb begin
		if (sym_data.symbol < SYM_LO || sym_data.symbol > SYM_HI) begin
			bin_in = '0;
		end else begin
			bin_in = BIN_W'(sym_data.symbol - SYM_LO);
		end
	end

	assign rd_addr = (state_q == ST_IDLE) ? bin_in : scan_q;
	assign rd_en   = accept || (state_q == ST_SCAN);
	assign wr_en   = (state_q == ST_INC);
	assign rd_val  = rdv_q ? rd_q : '0;
	assign inc_val = (rd_val < CNT_MAX) ? rd_val + CNT_W'(1) : rd_val;

	always_comb begin
		win_sym = SYM_W'(best_bin_q) + DASH;
		if (mode_q && best_q < height_q) begin
			win_sym = DASH;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			rdv_q <= vld_q[rd_addr];
		end
		if (wr_en) begin
			mem[bin_q] <= inc_val;
		end
		rd_bin_s1 <= scan_q;
		if (accept) begin
			bin_q  <= bin_in;
			last_q <= sym_data.last;
		end
		if (state_q == ST_DONE && out_free) begin
			vote_q.consensus_symbol <= win_sym;
			vote_q.winning_count    <= CNT_OUT_W'(best_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= 1'b0;
			height_q     <= '0;
			vld_q        <= '0;
			scan_q       <= '0;
			cmp_vld_s1   <= 1'b0;
			best_q       <= '0;
			best_bin_q   <= '0;
			vote_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (vote_valid_q && !vote_stall && state_q != ST_DONE) begin
				vote_valid_q <= 1'b0;
			end
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (cmp_vld_s1 && rd_val >= best_q) begin
				best_q     <= rd_val;
				best_bin_q <= rd_bin_s1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (height_q < CNT_MAX) begin
							height_q <= height_q + CNT_W'(1);
						end
						state_q <= ST_INC;
					end
				end
				ST_INC: begin
					vld_q[bin_q] <= 1'b1;
					scan_q       <= '0;
					best_q       <= '0;
					best_bin_q   <= '0;
					state_q      <= last_q ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					scan_q <= scan_q + BIN_W'(1);
					if (scan_q == BIN_W'(NUM_BINS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						vote_valid_q <= 1'b1;
						vld_q        <= '0;
						height_q     <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_vote_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vote_valid_q) |-> $past(state_q == ST_DONE))
		else $error("vote raised outside column end");

	a_height_sat: assert property (@(posedge clk) disable iff (!arst_n)
		height_q <= CNT_MAX)
		else $error("column height above saturation");

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		vote_valid_q |-> (vote_q.consensus_symbol >= DASH &&
			vote_q.consensus_symbol <= SYM_W'(SYM_HI)))
		else $error("consensus symbol out of range");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q < BIN_W'(NUM_BINS)))
		else $error("scan index beyond bin count");
`endif

endmodule
